// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the signed BCD unit RTL.
// No dependencies; pulled in with an include inside the module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the synchronous reset is low.
`define CHK_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/sbcd_pkg.sv =====
// Shared constants and digit helpers for the signed BCD arithmetic unit.
// No dependencies.
package sbcd_pkg;

    localparam int DIGITS = 16;
    localparam int MAG_W  = 4 * DIGITS;
    localparam int LVLS   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [63:0] MAG_MASK = {64{1'b1}} >> (64 - MAG_W);

    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_order;
    typedef logic [1:0] t_status;
    // Carry transfer of a digit span: bits [2c+1:2c] give carry out for carry in c.
    typedef logic [7:0] t_cmap;

    localparam t_cmd CMD_ADD = 3'd0;
    localparam t_cmd CMD_SUB = 3'd1;
    localparam t_cmd CMD_CMP = 3'd2;
    localparam t_cmd CMD_MUL = 3'd3;
    localparam t_cmd CMD_DIV = 3'd4;

    localparam t_order ORD_EQ   = 2'd0;
    localparam t_order ORD_GT   = 2'd1;
    localparam t_order ORD_LT   = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OVF  = 2'd1;
    localparam t_status ST_NEG  = 2'd2;

    // Decimal carry of a digit sum; sums reach 33 with nibbles above 9.
    function automatic logic [1:0] dec_carry(input logic [5:0] s);
        if (s >= 6'd30) return 2'd3;
        else if (s >= 6'd20) return 2'd2;
        else if (s >= 6'd10) return 2'd1;
        else return 2'd0;
    endfunction

    function automatic t_cmap add_map(input logic [3:0] x, input logic [3:0] y);
        t_cmap m;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            m[2*c +: 2] = dec_carry(6'({2'b00, x}) + 6'({2'b00, y}) + 6'(c));
        end
        return m;
    endfunction

    function automatic logic [3:0] add_digit(input logic [3:0] x, input logic [3:0] y,
                                             input logic [1:0] cin);
        logic [5:0] s;
        logic [5:0] r;
        s = 6'({2'b00, x}) + 6'({2'b00, y}) + 6'({4'b0000, cin});
        r = s - 6'(10 * int'(dec_carry(s)));
        return r[3:0];
    endfunction

    // Borrow out is 1 when x is below y plus the borrow in.
    function automatic t_cmap sub_map(input logic [3:0] x, input logic [3:0] y);
        t_cmap m;
        logic  b0;
        logic  b1;
        b0 = (x < y);
        b1 = (x <= y);
        m  = {1'b0, b1, 1'b0, b1, 1'b0, b1, 1'b0, b0};
        return m;
    endfunction

    function automatic logic [3:0] sub_digit(input logic [3:0] x, input logic [3:0] y,
                                             input logic bin);
        logic [3:0] d;
        d = x - 4'(bin) - y;
        if ({1'b0, x} < ({1'b0, y} + 5'(bin))) d = d + 4'd10;
        return d;
    endfunction

    // Carry map of f followed by g.
    function automatic t_cmap map_join(input t_cmap f, input t_cmap g);
        t_cmap h;
        h = '0;
        for (int c = 0; c < 4; c++) begin
            h[2*c +: 2] = g[2*f[2*c +: 2] +: 2];
        end
        return h;
    endfunction

endpackage

// ===== hdl/signed_bcd_arithmetic_unit.sv =====
// Signed BCD arithmetic unit: add, subtract, compare, times ten, divide by ten.
// Depends on sbcd_pkg and assert_macros.svh.
//
// One operation is taken on every clock where start is high; busy never rises, so
// the unit sustains one operation per cycle. Each result shows on the o_ ports for
// one cycle with o_done high, after the operation passes the operand register and
// then the result register. The decimal carry and borrow chains use a log-depth
// carry-map prefix over the digits, which sets the path between the two registers.
// There is no backpressure: a result not taken in its o_done cycle is gone.
module signed_bcd_arithmetic_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sbcd_pkg::t_cmd       i_command,
    input  logic [63:0]          i_a_digits,
    input  logic                 i_a_negative,
    input  logic [63:0]          i_b_digits,
    input  logic                 i_b_negative,
    output logic                 o_done,
    output logic [63:0]          o_result_digits,
    output logic                 o_result_negative,
    output sbcd_pkg::t_order     o_order,
    output sbcd_pkg::t_status    o_status,
    output logic signed [4:0]    o_remainder
);
    import sbcd_pkg::*;
    `include "assert_macros.svh"

    // operand register
    logic        r_in_valid;
    t_cmd        r_cmd;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic        r_a_neg;
    logic        r_b_neg;

    // result register
    logic               r_done, n_done;
    logic [63:0]        r_res, n_res;
    logic               r_res_neg, n_res_neg;
    t_order             r_order, n_order;
    t_status            r_status, n_status;
    logic signed [4:0]  r_rem, n_rem;

    logic [63:0] w_am;
    logic [63:0] w_bm;
    logic        w_an;
    logic        w_bn;
    logic [63:0] w_sx;
    logic [63:0] w_sy;
    logic [63:0] w_sum;
    logic [63:0] w_diff;
    logic        w_add_ovf;
    t_cmap       w_amap [LVLS+1][DIGITS];
    t_cmap       w_smap [LVLS+1][DIGITS];
    logic [3:0]  w_low;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        if (start) begin
            r_cmd   <= i_command;
            r_a     <= i_a_digits;
            r_b     <= i_b_digits;
            r_a_neg <= i_a_negative;
            r_b_neg <= i_b_negative;
        end
    end

    assign w_am = r_a & MAG_MASK;
    assign w_bm = r_b & MAG_MASK;
    assign w_an = r_a_neg && (w_am != '0);
    assign w_bn = r_b_neg && (w_bm != '0);

    always_comb begin
        if (w_an != w_bn) begin
            n_order = w_an ? ORD_LT : ORD_GT;
        end else if (w_am == w_bm) begin
            n_order = ORD_EQ;
        end else if ((w_am > w_bm) != w_an) begin
            n_order = ORD_GT;
        end else begin
            n_order = ORD_LT;
        end
    end

    // swap subtract operands when a is below b
    assign w_sx = (n_order == ORD_LT) ? w_bm : w_am;
    assign w_sy = (n_order == ORD_LT) ? w_am : w_bm;

    // carry and borrow prefix over the digits
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_amap[0][i] = add_map(w_am[4*i +: 4], w_bm[4*i +: 4]);
            w_smap[0][i] = sub_map(w_sx[4*i +: 4], w_sy[4*i +: 4]);
        end
        for (int l = 0; l < LVLS; l++) begin
            for (int i = 0; i < DIGITS; i++) begin
                if (i >= (1 << l)) begin
                    w_amap[l+1][i] = map_join(w_amap[l][i - (1 << l)], w_amap[l][i]);
                    w_smap[l+1][i] = map_join(w_smap[l][i - (1 << l)], w_smap[l][i]);
                end else begin
                    w_amap[l+1][i] = w_amap[l][i];
                    w_smap[l+1][i] = w_smap[l][i];
                end
            end
        end
    end

    always_comb begin
        w_sum  = '0;
        w_diff = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (i == 0) begin
                w_sum[3:0]  = add_digit(w_am[3:0], w_bm[3:0], 2'd0);
                w_diff[3:0] = sub_digit(w_sx[3:0], w_sy[3:0], 1'b0);
            end else begin
                w_sum[4*i +: 4]  = add_digit(w_am[4*i +: 4], w_bm[4*i +: 4],
                                             w_amap[LVLS][i-1][1:0]);
                w_diff[4*i +: 4] = sub_digit(w_sx[4*i +: 4], w_sy[4*i +: 4],
                                             w_smap[LVLS][i-1][0]);
            end
        end
        w_add_ovf = (w_amap[LVLS][DIGITS-1][1:0] != 2'd0);
    end

    assign w_low = w_am[3:0];

    always_comb begin
        n_done    = r_in_valid;
        n_res     = '0;
        n_res_neg = 1'b0;
        n_status  = ST_OK;
        n_rem     = '0;
        unique case (r_cmd)
            CMD_ADD: begin
                n_res    = w_sum;
                n_status = w_add_ovf ? ST_OVF : ST_OK;
            end
            CMD_SUB: begin
                n_res = w_diff;
                if (n_order == ORD_LT) begin
                    n_res_neg = 1'b1;
                    n_status  = ST_NEG;
                end
            end
            CMD_MUL: begin
                n_res     = (w_am << 4) & MAG_MASK;
                n_res_neg = w_an;
                n_status  = (w_am[4*(DIGITS-1) +: 4] != 4'd0) ? ST_OVF : ST_OK;
            end
            CMD_DIV: begin
                n_res     = w_am >> 4;
                n_res_neg = w_an;
                n_rem     = w_an ? (5'sd0 - $signed({1'b0, w_low}))
                                 : $signed({1'b0, w_low});
            end
            default: begin
                // compare and unused codes leave the result at zero
                n_res = '0;
            end
        endcase
        if (n_res == '0) n_res_neg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_res     <= n_res;
        r_res_neg <= n_res_neg;
        r_order   <= n_order;
        r_status  <= n_status;
        r_rem     <= n_rem;
    end

    assign o_done            = r_done;
    assign o_result_digits   = r_res;
    assign o_result_negative = r_res_neg;
    assign o_order           = r_order;
    assign o_status          = r_status;
    assign o_remainder       = r_rem;

    `CHK_SYNC(a_beat_latency, i_clk, i_rst_n, start |-> ##2 o_done, "operation beat lost or late")
    `CHK_SYNC(a_zero_positive, i_clk, i_rst_n, (o_done && (o_result_digits == '0)) |-> !o_result_negative, "zero result marked negative")
    `CHK_SYNC(a_neg_status, i_clk, i_rst_n, (o_done && (o_status == ST_NEG)) |-> (o_order == ORD_LT), "negative status without a below b")
    `CHK_SYNC(a_upper_clear, i_clk, i_rst_n, o_done |-> ((o_result_digits & ~MAG_MASK) == '0), "digits above width not cleared")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for signed_bcd_arithmetic_unit: directed corner cases, then
// random operand pairs under random start gaps, checked against a decimal predictor.
// Depends on sbcd_pkg and the signed_bcd_arithmetic_unit RTL.
module tb;
    import sbcd_pkg::*;

    localparam int   ITEM_COUNT   = 550;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   DIGIT_MAX    = 9;
    localparam t_cmd CMD_SPARE5   = 3'd5;
    localparam t_cmd CMD_SPARE6   = 3'd6;
    localparam t_cmd CMD_SPARE7   = 3'd7;
    localparam logic [63:0] ALL_NINES = 64'h9999_9999_9999_9999 & MAG_MASK;

    typedef struct packed {
        logic [63:0]        digits;
        logic               negative;
        t_order             order;
        t_status            status;
        logic signed [4:0]  remainder;
    } bcd_result_t;

    class bcd_result_board;
        bcd_result_t expected_q[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [63:0] decimal_sum(input logic [63:0] x, input logic [63:0] y,
                                          output logic carry_out);
            logic [63:0] r;
            int          carry;
            int          s;
            r     = '0;
            carry = 0;
            for (int i = 0; i < DIGITS; i++) begin
                s = carry + int'(x[4*i +: 4]) + int'(y[4*i +: 4]);
                r[4*i +: 4] = 4'(s % 10);
                carry = s / 10;
            end
            carry_out = (carry != 0);
            return r;
        endfunction

        // Borrow out of the top digit is dropped; out-of-range nibbles wrap mod 16.
        function logic [63:0] decimal_diff(input logic [63:0] x, input logic [63:0] y);
            logic [63:0] r;
            int          borrow;
            int          xd;
            int          yd;
            int          d;
            r      = '0;
            borrow = 0;
            for (int i = 0; i < DIGITS; i++) begin
                xd = int'(x[4*i +: 4]) - borrow;
                yd = int'(y[4*i +: 4]);
                if (xd >= yd) begin
                    d      = xd - yd;
                    borrow = 0;
                end else begin
                    d      = 10 + xd - yd;
                    borrow = 1;
                end
                r[4*i +: 4] = 4'(d);
            end
            return r;
        endfunction

        function void note_operation(input t_cmd cmd, input logic [63:0] a_raw,
                                     input logic a_sign, input logic [63:0] b_raw,
                                     input logic b_sign);
            bcd_result_t want;
            logic [63:0] am;
            logic [63:0] bm;
            logic        an;
            logic        bn;
            logic        carry;
            logic [3:0]  low;
            am   = a_raw & MAG_MASK;
            bm   = b_raw & MAG_MASK;
            an   = a_sign && (am != 0);
            bn   = b_sign && (bm != 0);
            want = '0;

            // Zero counts as positive, so a negative zero compares equal to zero.
            if (an != bn)
                want.order = an ? ORD_LT : ORD_GT;
            else if (am == bm)
                want.order = ORD_EQ;
            else if ((am > bm) != an)
                want.order = ORD_GT;
            else
                want.order = ORD_LT;

            case (cmd)
                CMD_ADD: begin
                    want.digits = decimal_sum(am, bm, carry);
                    want.status = carry ? ST_OVF : ST_OK;
                end
                CMD_SUB: begin
                    if (want.order != ORD_LT) begin
                        want.digits = decimal_diff(am, bm);
                    end else begin
                        want.digits   = decimal_diff(bm, am);
                        want.negative = 1'b1;
                        want.status   = ST_NEG;
                    end
                end
                CMD_MUL: begin
                    want.digits   = (am << 4) & MAG_MASK;
                    want.negative = an;
                    want.status   = (am[4*DIGITS-4 +: 4] != 0) ? ST_OVF : ST_OK;
                end
                CMD_DIV: begin
                    low            = am[3:0];
                    want.digits    = am >> 4;
                    want.negative  = an;
                    want.remainder = an ? 5'(-int'(low)) : 5'(low);
                end
                default: ;
            endcase
            if (want.digits == 0)
                want.negative = 1'b0;
            expected_q.push_back(want);
        endfunction

        function void report(input string field, input logic [63:0] want,
                             input logic [63:0] got);
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(input bcd_result_t got);
            bcd_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (want.digits !== got.digits)
                report("result_digits", want.digits, got.digits);
            if (want.negative !== got.negative)
                report("result_negative", 64'(want.negative), 64'(got.negative));
            if (want.order !== got.order)
                report("order", 64'(want.order), 64'(got.order));
            if (want.status !== got.status)
                report("status", 64'(want.status), 64'(got.status));
            if (want.remainder !== got.remainder)
                report("remainder", 64'(want.remainder), 64'(got.remainder));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n           = 1'b0;
    logic               start             = 1'b0;
    t_cmd               i_command         = CMD_ADD;
    logic [63:0]        i_a_digits        = '0;
    logic               i_a_negative      = 1'b0;
    logic [63:0]        i_b_digits        = '0;
    logic               i_b_negative      = 1'b0;
    logic               busy;
    logic               o_done;
    logic [63:0]        o_result_digits;
    logic               o_result_negative;
    t_order             o_order;
    t_status            o_status;
    logic signed [4:0]  o_remainder;

    bcd_result_board    board;
    logic               no_idle = 1'b0;
    int                 cycle_count;

    signed_bcd_arithmetic_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_a_digits        (i_a_digits),
        .i_a_negative      (i_a_negative),
        .i_b_digits        (i_b_digits),
        .i_b_negative      (i_b_negative),
        .o_done            (o_done),
        .o_result_digits   (o_result_digits),
        .o_result_negative (o_result_negative),
        .o_order           (o_order),
        .o_status          (o_status),
        .o_remainder       (o_remainder)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Take each result beat at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result('{o_result_digits, o_result_negative, o_order,
                                 o_status, o_remainder});
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [63:0] pick_digits();
        int          kind;
        int          len;
        logic [63:0] v;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, DIGITS);
        v    = '0;
        if (kind < 10)
            v = '0;
        else if (kind < 25)
            v = {$urandom, $urandom};
        else if (kind < 35)
            v = ALL_NINES >> (4 * (DIGITS - len));
        else
            for (int i = 0; i < len; i++)
                v[4*i +: 4] = 4'($urandom_range(0, DIGIT_MAX));
        return v;
    endfunction

    // Hold start until the beat is taken, then note it and idle for a random gap.
    task automatic issue(input t_cmd cmd, input logic [63:0] a, input logic an,
                         input logic [63:0] b, input logic bn);
        int gap;
        start        <= 1'b1;
        i_command    <= cmd;
        i_a_digits   <= a;
        i_a_negative <= an;
        i_b_digits   <= b;
        i_b_negative <= bn;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        board.note_operation(cmd, a, an, b, bn);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_cmd        cmd;
        logic [63:0] a;
        logic [63:0] b;
        int          roll;

        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_ADD, 64'h0, 1'b0, 64'h0, 1'b0);
        issue(CMD_ADD, ALL_NINES, 1'b0, 64'h1, 1'b0);
        issue(CMD_ADD, ALL_NINES, 1'b1, ALL_NINES, 1'b1);
        issue(CMD_ADD, {64{1'b1}}, 1'b0, {64{1'b1}}, 1'b1);
        issue(CMD_SUB, 64'h500, 1'b0, 64'h123, 1'b0);
        issue(CMD_SUB, 64'h123, 1'b0, 64'h500, 1'b0);
        issue(CMD_SUB, 64'h4567, 1'b1, 64'h4567, 1'b1);
        issue(CMD_SUB, 64'h5, 1'b1, 64'h3, 1'b0);
        issue(CMD_SUB, 64'h0, 1'b1, 64'h0, 1'b0);
        issue(CMD_SUB, 64'h0, 1'b0, 64'h1, 1'b1);
        issue(CMD_SUB, {64{1'b1}}, 1'b0, 64'h1234, 1'b0);
        issue(CMD_CMP, 64'h0, 1'b1, 64'h0, 1'b0);
        issue(CMD_CMP, 64'h7, 1'b1, 64'h3, 1'b1);
        issue(CMD_CMP, 64'h3, 1'b1, 64'h7, 1'b1);
        issue(CMD_MUL, 64'h9000_0000_0000_0001, 1'b1, 64'h0, 1'b0);
        issue(CMD_MUL, 64'h0, 1'b1, 64'h0, 1'b0);
        issue(CMD_MUL, ALL_NINES, 1'b0, ALL_NINES, 1'b0);
        issue(CMD_DIV, 64'h7, 1'b1, 64'h0, 1'b0);
        issue(CMD_DIV, 64'hF, 1'b1, 64'h0, 1'b1);
        issue(CMD_DIV, 64'h12345, 1'b0, 64'h0, 1'b0);
        issue(CMD_DIV, {64{1'b1}}, 1'b0, 64'h0, 1'b0);
        issue(CMD_SPARE5, 64'h42, 1'b1, 64'h17, 1'b0);
        issue(CMD_SPARE6, 64'h17, 1'b0, 64'h42, 1'b1);
        issue(CMD_SPARE7, ALL_NINES, 1'b1, ALL_NINES, 1'b1);

        for (int n = 0; n < ITEM_COUNT; n++) begin
            // Every so often run a stretch back to back.
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 90)
                cmd = t_cmd'($urandom_range(CMD_ADD, CMD_DIV));
            else
                cmd = t_cmd'($urandom_range(CMD_SPARE5, CMD_SPARE7));
            a    = pick_digits();
            roll = $urandom_range(0, 99);
            if (roll < 15)
                b = a;
            else if (roll < 25)
                b = a ^ (64'h1 << (4 * $urandom_range(0, DIGITS - 1)));
            else
                b = pick_digits();
            issue(cmd, a, 1'($urandom), b, 1'($urandom));
        end
        start <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
